// File: hw/rtl/stepper_full_step_sequencer_unit_macros.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef STEPPER_FULL_STEP_SEQUENCER_UNIT_MACROS_SVH
`define STEPPER_FULL_STEP_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ssq_pkg.sv
`timescale 1ns / 1ps

package ssq_pkg;

   // Fixed field widths
   localparam int LEVEL_BITS        = 8;
   localparam int DELAY_FIELD_BITS  = 20;
   localparam int LENGTH_FIELD_BITS = 16;
   localparam int PATTERN_BITS      = 4;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 32;

   // Default widths of the delay and length stores
   localparam int DELAY_BITS_DEF  = 20;
   localparam int LENGTH_BITS_DEF = 16;

   // Register values after reset
   localparam logic [LEVEL_BITS-1:0]        RESET_MAX_LEVEL   = 8'd10;
   localparam logic [LEVEL_BITS-1:0]        RESET_SPEED_LEVEL = 8'd1;
   localparam logic [DELAY_FIELD_BITS-1:0]  RESET_DELAY_MIN   = 20'd2000;
   localparam logic [DELAY_FIELD_BITS-1:0]  RESET_DELAY_MAX   = 20'd20000;
   localparam logic [LENGTH_FIELD_BITS-1:0] RESET_FWD_LENGTH  = 16'd1;
   localparam logic [LENGTH_FIELD_BITS-1:0] RESET_BWD_LENGTH  = 16'd1;

   localparam logic [LEVEL_BITS-1:0] MIN_LEVEL     = 8'd1;
   localparam logic [LEVEL_BITS-1:0] MIN_MAX_LEVEL = 8'd2;

   // Request operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   // Direction codes
   localparam logic DIR_FWD = 1'b0;
   localparam logic DIR_BWD = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LEVEL   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_LEVEL = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_MIN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_MAX   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FWD_LENGTH  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BWD_LENGTH  = 3'd5;

   // Coil patterns, A+,A-,B+,B- as bits 3..0
   localparam logic [PATTERN_BITS-1:0] COILS_OFF = 4'b0000;
   localparam logic [PATTERN_BITS-1:0] PAT_AB    = 4'b1010;
   localparam logic [PATTERN_BITS-1:0] PAT_AnB   = 4'b1001;
   localparam logic [PATTERN_BITS-1:0] PAT_nAnB  = 4'b0101;
   localparam logic [PATTERN_BITS-1:0] PAT_nAB   = 4'b0110;

   // Status of the hold-time unit towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } ssq_hold_stat_type;

   // Coil pattern for a phase of the four-phase cycle
   function automatic logic [PATTERN_BITS-1:0] ssq_seq(input logic bwd,
                                                       input logic [1:0] ph);
      logic [PATTERN_BITS-1:0] pat;
      case (ph)
         2'd0:    pat = bwd ? PAT_nAB  : PAT_AB;
         2'd1:    pat = bwd ? PAT_nAnB : PAT_AnB;
         2'd2:    pat = bwd ? PAT_AnB  : PAT_nAnB;
         2'd3:    pat = bwd ? PAT_AB   : PAT_nAB;
         default: pat = COILS_OFF;
      endcase
      return pat;
   endfunction

endpackage

// File: hw/rtl/ssq_hold_unit.sv
`timescale 1ns / 1ps

// Hold time from speed level: clamp, one multiply, then a bit-serial
// restoring divide through a single shared subtractor.
module ssq_hold_unit #(
   parameter int DELAY_BITS = ssq_pkg::DELAY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ssq_pkg::LEVEL_BITS-1:0]  level,
   input  logic [ssq_pkg::LEVEL_BITS-1:0]  top_level,
   input  logic [DELAY_BITS-1:0]           dly_fast,
   input  logic [DELAY_BITS-1:0]           dly_slow,
   output ssq_pkg::ssq_hold_stat_type      stat,
   output logic [DELAY_BITS-1:0]           hold
);
   import ssq_pkg::*;

   localparam int PROD_BITS = DELAY_BITS + LEVEL_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS);

   typedef enum logic [3:0] {
      H_IDLE = 4'b0001,
      H_MUL  = 4'b0010,
      H_DIV  = 4'b0100,
      H_END  = 4'b1000
   } hold_state_type;

   hold_state_type          state_ff, state_in;
   logic [DELAY_BITS-1:0]   mag_ff, mag_in;
   logic [DELAY_BITS-1:0]   dmax_ff, dmax_in;
   logic                    neg_ff, neg_in;
   logic [LEVEL_BITS-1:0]   lvm1_ff, lvm1_in;
   logic [LEVEL_BITS-1:0]   div_ff, div_in;
   logic [LEVEL_BITS-1:0]   rem_ff, rem_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;

   logic [LEVEL_BITS-1:0]   lvl;
   logic [LEVEL_BITS:0]     rem_sh, rem_sub;
   logic                    q_bit;
   logic [DELAY_BITS:0]     dsum;

   // Clamp the level into 1..top
   always_comb begin
      if (level < MIN_LEVEL) begin
         lvl = MIN_LEVEL;
      end else if (level > top_level) begin
         lvl = top_level;
      end else begin
         lvl = level;
      end
   end

   // One restoring divide step
   assign rem_sh  = {rem_ff, prod_ff[PROD_BITS-1]};
   assign q_bit   = (rem_sh >= {1'b0, div_ff});
   assign rem_sub = q_bit ? (rem_sh - {1'b0, div_ff}) : rem_sh;

   // Final subtract from the slow delay (an add when the delays are crossed), at least one tick
   always_comb begin
      if (neg_ff) begin
         dsum = {1'b0, dmax_ff} + {1'b0, prod_ff[DELAY_BITS-1:0]};
      end else begin
         dsum = {1'b0, dmax_ff} - {1'b0, prod_ff[DELAY_BITS-1:0]};
      end
      if (dsum == '0) begin
         hold = DELAY_BITS'(1);
      end else begin
         hold = dsum[DELAY_BITS-1:0];
      end
   end

   assign stat.busy = (state_ff != H_IDLE);
   assign stat.done = (state_ff == H_END);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      dmax_in  = dmax_ff;
      neg_in   = neg_ff;
      lvm1_in  = lvm1_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               neg_in   = (dly_slow < dly_fast);
               mag_in   = (dly_slow < dly_fast) ? (dly_fast - dly_slow)
                                                : (dly_slow - dly_fast);
               dmax_in  = dly_slow;
               lvm1_in  = lvl - MIN_LEVEL;
               div_in   = top_level - MIN_LEVEL;
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            prod_in  = PROD_BITS'(mag_ff) * PROD_BITS'(lvm1_ff);
            rem_in   = '0;
            cnt_in   = CNT_BITS'(PROD_BITS - 1);
            state_in = H_DIV;
         end
         H_DIV: begin
            rem_in  = rem_sub[LEVEL_BITS-1:0];
            prod_in = {prod_ff[PROD_BITS-2:0], q_bit};
            cnt_in  = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = H_END;
            end
         end
         H_END: begin
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      dmax_ff <= dmax_in;
      neg_ff  <= neg_in;
      lvm1_ff <= lvm1_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// File: hw/rtl/stepper_full_step_sequencer_unit.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_ready  operation, direction, speed, single cycle
// rsp_       out        rsp_valid/rsp_ready  coil pattern, busy, done, rejected
// csr_       in         csr_valid/csr_ready  register index, write data
//
// A tick request, and a move command that arrives while a move runs, are
// answered through the response register. A move command accepted while idle
// waits for the bit-serial divider in ssq_hold_unit; no request is taken meanwhile.
// Reset is synchronous: coils off, idle, registers at their defaults.
// The response register lets a new request in while a stalled response is taken.
`include "stepper_full_step_sequencer_unit_macros.svh"

module stepper_full_step_sequencer_unit #(
   parameter int DELAY_BITS  = ssq_pkg::DELAY_BITS_DEF,
   parameter int LENGTH_BITS = ssq_pkg::LENGTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic                                req_direction,
   input  logic                                req_use_temp_speed,
   input  logic [ssq_pkg::LEVEL_BITS-1:0]      req_temp_speed,
   input  logic                                req_single_cycle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ssq_pkg::PATTERN_BITS-1:0]    rsp_coil_pattern,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_rejected,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssq_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ssq_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ssq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_CALC = 2'b10
   } seq_state_type;

   // Configuration registers
   logic [LEVEL_BITS-1:0]  max_level_ff, max_level_in;
   logic [LEVEL_BITS-1:0]  speed_level_ff, speed_level_in;
   logic [DELAY_BITS-1:0]  delay_min_ff, delay_min_in;
   logic [DELAY_BITS-1:0]  delay_max_ff, delay_max_in;
   logic [LENGTH_BITS-1:0] fwd_length_ff, fwd_length_in;
   logic [LENGTH_BITS-1:0] bwd_length_ff, bwd_length_in;

   // Move state
   seq_state_type           state_ff, state_in;
   logic                    active_ff, active_in;
   logic                    backward_ff, backward_in;
   logic [1:0]              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]  cycles_left_ff, cycles_left_in;
   logic [DELAY_BITS-1:0]   hold_time_ff, hold_time_in;
   logic [DELAY_BITS-1:0]   hold_left_ff, hold_left_in;
   logic [PATTERN_BITS-1:0] pattern_ff, pattern_in;
   logic [LENGTH_BITS-1:0]  len_pend_ff, len_pend_in;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_done_ff, rsp_done_in;
   logic                    rsp_rej_ff, rsp_rej_in;

   logic                          req_fire;
   logic                          hu_start;
   logic [LEVEL_BITS-1:0]         hu_level;
   ssq_hold_stat_type             hu_stat;
   logic [DELAY_BITS-1:0]         hu_hold;
   logic [DELAY_BITS-1:0]         hl_dec;
   logic [LENGTH_BITS-1:0]        cyc_dec;
   logic [DELAY_BITS+DELAY_FIELD_BITS-1:0]   dly_ext;
   logic [LENGTH_BITS+LENGTH_FIELD_BITS-1:0] len_ext;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign hu_start  = req_fire && (req_operation == OP_MOVE) && !active_ff;
   assign hu_level  = req_use_temp_speed ? req_temp_speed : speed_level_ff;

   // Fit write data to the store widths
   assign dly_ext = {{DELAY_BITS{1'b0}}, csr_wdata[DELAY_FIELD_BITS-1:0]};
   assign len_ext = {{LENGTH_BITS{1'b0}}, csr_wdata[LENGTH_FIELD_BITS-1:0]};

   // Register writes
   always_comb begin
      max_level_in   = max_level_ff;
      speed_level_in = speed_level_ff;
      delay_min_in   = delay_min_ff;
      delay_max_in   = delay_max_ff;
      fwd_length_in  = fwd_length_ff;
      bwd_length_in  = bwd_length_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_LEVEL: begin
               if (csr_wdata[LEVEL_BITS-1:0] >= MIN_MAX_LEVEL) begin
                  max_level_in = csr_wdata[LEVEL_BITS-1:0];
               end
            end
            CSR_SPEED_LEVEL: speed_level_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_DELAY_MIN:   delay_min_in   = dly_ext[DELAY_BITS-1:0];
            CSR_DELAY_MAX:   delay_max_in   = dly_ext[DELAY_BITS-1:0];
            CSR_FWD_LENGTH:  fwd_length_in  = len_ext[LENGTH_BITS-1:0];
            CSR_BWD_LENGTH:  bwd_length_in  = len_ext[LENGTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   ssq_hold_unit #(
      .DELAY_BITS (DELAY_BITS)
   ) u_hold (
      .clock     (clock),
      .reset     (reset),
      .start     (hu_start),
      .level     (hu_level),
      .top_level (max_level_ff),
      .dly_fast  (delay_min_ff),
      .dly_slow  (delay_max_ff),
      .stat      (hu_stat),
      .hold      (hu_hold)
   );

   assign hl_dec  = hold_left_ff - DELAY_BITS'(1);
   assign cyc_dec = cycles_left_ff - LENGTH_BITS'(1);

   // Sequencer: ticks, rejects and move start
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      backward_in    = backward_ff;
      phase_in       = phase_ff;
      cycles_left_in = cycles_left_ff;
      hold_time_in   = hold_time_ff;
      hold_left_in   = hold_left_ff;
      pattern_in     = pattern_ff;
      len_pend_in    = len_pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_done_in    = rsp_done_ff;
      rsp_rej_in     = rsp_rej_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_done_in = 1'b0;
               rsp_rej_in  = 1'b0;
               if (req_operation == OP_MOVE) begin
                  if (active_ff) begin
                     // drop the command, flag it
                     rsp_valid_in = 1'b1;
                     rsp_rej_in   = 1'b1;
                  end else begin
                     backward_in = (req_direction == DIR_BWD);
                     if (req_single_cycle) begin
                        len_pend_in = LENGTH_BITS'(1);
                     end else if (req_direction == DIR_BWD) begin
                        len_pend_in = bwd_length_ff;
                     end else begin
                        len_pend_in = fwd_length_ff;
                     end
                     state_in = S_CALC;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  if (active_ff) begin
                     // count down the hold, advance the phase at zero
                     hold_left_in = hl_dec;
                     if (hl_dec == '0) begin
                        if (phase_ff == 2'd3) begin
                           phase_in       = 2'd0;
                           cycles_left_in = cyc_dec;
                           if (cyc_dec == '0) begin
                              active_in   = 1'b0;
                              pattern_in  = COILS_OFF;
                              rsp_done_in = 1'b1;
                           end else begin
                              pattern_in   = ssq_seq(backward_ff, 2'd0);
                              hold_left_in = hold_time_ff;
                           end
                        end else begin
                           phase_in     = phase_ff + 2'd1;
                           pattern_in   = ssq_seq(backward_ff, phase_ff + 2'd1);
                           hold_left_in = hold_time_ff;
                        end
                     end
                  end
               end
            end
         end
         S_CALC: begin
            if (hu_stat.done) begin
               hold_time_in = hu_hold;
               rsp_valid_in = 1'b1;
               phase_in     = 2'd0;
               if (len_pend_ff == '0) begin
                  pattern_in     = COILS_OFF;
                  cycles_left_in = '0;
                  rsp_done_in    = 1'b1;
               end else begin
                  active_in      = 1'b1;
                  cycles_left_in = len_pend_ff;
                  hold_left_in   = hu_hold;
                  pattern_in     = ssq_seq(backward_ff, 2'd0);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff   <= RESET_MAX_LEVEL;
         speed_level_ff <= RESET_SPEED_LEVEL;
         delay_min_ff   <= DELAY_BITS'(RESET_DELAY_MIN);
         delay_max_ff   <= DELAY_BITS'(RESET_DELAY_MAX);
         fwd_length_ff  <= LENGTH_BITS'(RESET_FWD_LENGTH);
         bwd_length_ff  <= LENGTH_BITS'(RESET_BWD_LENGTH);
         state_ff       <= S_IDLE;
         active_ff      <= 1'b0;
         backward_ff    <= 1'b0;
         phase_ff       <= 2'd0;
         cycles_left_ff <= '0;
         hold_time_ff   <= '0;
         hold_left_ff   <= '0;
         pattern_ff     <= COILS_OFF;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_level_ff   <= max_level_in;
         speed_level_ff <= speed_level_in;
         delay_min_ff   <= delay_min_in;
         delay_max_ff   <= delay_max_in;
         fwd_length_ff  <= fwd_length_in;
         bwd_length_ff  <= bwd_length_in;
         state_ff       <= state_in;
         active_ff      <= active_in;
         backward_ff    <= backward_in;
         phase_ff       <= phase_in;
         cycles_left_ff <= cycles_left_in;
         hold_time_ff   <= hold_time_in;
         hold_left_ff   <= hold_left_in;
         pattern_ff     <= pattern_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      len_pend_ff <= len_pend_in;
      rsp_done_ff <= rsp_done_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coil_pattern = pattern_ff;
   assign rsp_busy_res     = active_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_rejected     = rsp_rej_ff;

   `SSQ_ASSERT_NOW(a_coils_match_active, clock, reset, 1'b1,
      (pattern_ff != COILS_OFF) == active_ff, "coil pattern disagrees with busy")
   `SSQ_ASSERT_NOW(a_hold_nonzero, clock, reset, active_ff,
      hold_left_ff != '0, "hold counter at zero during a move")
   `SSQ_ASSERT_NOW(a_calc_tracks_unit, clock, reset, state_ff == S_CALC,
      hu_stat.busy && !req_ready, "hold unit idle or request taken during calculation")
   `SSQ_ASSERT_NEXT(a_start_enters_calc, clock, reset, hu_start,
      state_ff == S_CALC && hu_stat.busy, "move start did not enter calculation")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ssq_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 6;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   // Index with no register behind it
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic                  op;
      logic                  dir;
      logic                  use_temp;
      logic [LEVEL_BITS-1:0] temp;
      logic                  single;
   } coil_req_type;

   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic                    busy;
      logic                    done;
      logic                    rejected;
   } coil_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_operation = OP_TICK;
   logic                      req_direction = DIR_FWD;
   logic                      req_use_temp_speed = 1'b0;
   logic [LEVEL_BITS-1:0]     req_temp_speed = '0;
   logic                      req_single_cycle = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PATTERN_BITS-1:0]   rsp_coil_pattern;
   logic                      rsp_busy_res;
   logic                      rsp_done_res;
   logic                      rsp_rejected;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Predicted register file
   logic [LEVEL_BITS-1:0]        cf_max_level;
   logic [LEVEL_BITS-1:0]        cf_speed_level;
   logic [DELAY_FIELD_BITS-1:0]  cf_delay_min;
   logic [DELAY_FIELD_BITS-1:0]  cf_delay_max;
   logic [LENGTH_FIELD_BITS-1:0] cf_fwd_len;
   logic [LENGTH_FIELD_BITS-1:0] cf_bwd_len;

   // Predicted sequencer state
   logic                         sq_active;
   logic                         sq_backward;
   logic [1:0]                   sq_phase;
   logic [LENGTH_FIELD_BITS-1:0] sq_cycles;
   logic [DELAY_FIELD_BITS-1:0]  sq_hold_time;
   logic [DELAY_FIELD_BITS-1:0]  sq_hold_left;
   logic [PATTERN_BITS-1:0]      sq_pattern;

   coil_rsp_type coil_expect_q[$];

   bit idle_on = 1'b1;
   int n_errors = 0;
   int n_sent = 0;
   int n_work = 0;
   int n_results = 0;
   int n_moves = 0;
   int n_rejected = 0;
   int n_done = 0;
   int n_csr = 0;
   int n_settings = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;

   stepper_full_step_sequencer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_direction      (req_direction),
      .req_use_temp_speed (req_use_temp_speed),
      .req_temp_speed     (req_temp_speed),
      .req_single_cycle   (req_single_cycle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coil_pattern   (rsp_coil_pattern),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_rejected       (rsp_rejected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // Coil pattern for a phase; backward runs the forward table in reverse
   function automatic logic [PATTERN_BITS-1:0] coil_phase_pattern(input logic bwd,
                                                                 input logic [1:0] ph);
      logic [1:0] slot;
      slot = bwd ? 2'd3 - ph : ph;
      case (slot)
         2'd0:    return PAT_AB;
         2'd1:    return PAT_AnB;
         2'd2:    return PAT_nAnB;
         default: return PAT_nAB;
      endcase
   endfunction

   // Hold time per phase from a speed level, truncating toward zero
   function automatic logic [DELAY_FIELD_BITS-1:0] phase_hold(input logic [LEVEL_BITS-1:0] lvl_in);
      longint lv, top, dmax, dmin, q, d;
      lv = lvl_in;
      top = cf_max_level;
      dmax = cf_delay_max;
      dmin = cf_delay_min;
      if (lv < MIN_LEVEL) lv = MIN_LEVEL;
      if (lv > top) lv = top;
      q = ((dmax - dmin) * (lv - 1)) / (top - 1);
      d = dmax - q;
      if (d < 1) d = 1;
      return d[DELAY_FIELD_BITS-1:0];
   endfunction

   // Advance the predicted sequencer by one request and return its response
   function automatic coil_rsp_type step_coils(input coil_req_type r);
      coil_rsp_type o;
      logic [LEVEL_BITS-1:0] lvl;
      logic [LENGTH_FIELD_BITS-1:0] len;
      o.done = 1'b0;
      o.rejected = 1'b0;
      if (r.op == OP_MOVE) begin
         if (sq_active) begin
            o.rejected = 1'b1;
            n_rejected++;
         end else begin
            lvl = r.use_temp ? r.temp : cf_speed_level;
            len = r.single ? 16'd1 : ((r.dir == DIR_BWD) ? cf_bwd_len : cf_fwd_len);
            sq_backward = (r.dir == DIR_BWD);
            sq_hold_time = phase_hold(lvl);
            n_moves++;
            n_work++;
            if (len == 0) begin
               sq_pattern = COILS_OFF;
               sq_cycles = '0;
               o.done = 1'b1;
               n_done++;
            end else begin
               sq_active = 1'b1;
               sq_phase = 2'd0;
               sq_cycles = len;
               sq_hold_left = sq_hold_time;
               sq_pattern = coil_phase_pattern(sq_backward, sq_phase);
            end
         end
      end else if (sq_active) begin
         n_work++;
         sq_hold_left = sq_hold_left - 1'b1;
         if (sq_hold_left == 0) begin
            if (sq_phase == 2'd3) begin
               sq_phase = 2'd0;
               sq_cycles = sq_cycles - 1'b1;
               if (sq_cycles == 0) begin
                  sq_active = 1'b0;
                  sq_pattern = COILS_OFF;
                  o.done = 1'b1;
                  n_done++;
               end
            end else begin
               sq_phase = sq_phase + 1'b1;
            end
            if (sq_active) begin
               sq_pattern = coil_phase_pattern(sq_backward, sq_phase);
               sq_hold_left = sq_hold_time;
            end
         end
      end
      o.pattern = sq_pattern;
      o.busy = sq_active;
      return o;
   endfunction

   // Apply a register write to the predicted register file
   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] d);
      case (idx)
         CSR_MAX_LEVEL:   if (d[LEVEL_BITS-1:0] >= MIN_MAX_LEVEL) cf_max_level = d[LEVEL_BITS-1:0];
         CSR_SPEED_LEVEL: cf_speed_level = d[LEVEL_BITS-1:0];
         CSR_DELAY_MIN:   cf_delay_min = d[DELAY_FIELD_BITS-1:0];
         CSR_DELAY_MAX:   cf_delay_max = d[DELAY_FIELD_BITS-1:0];
         CSR_FWD_LENGTH:  cf_fwd_len = d[LENGTH_FIELD_BITS-1:0];
         CSR_BWD_LENGTH:  cf_bwd_len = d[LENGTH_FIELD_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic coil_req_type make_move(input logic dir, input logic use_temp,
                                              input logic [LEVEL_BITS-1:0] temp,
                                              input logic single);
      coil_req_type r;
      r.op = OP_MOVE;
      r.dir = dir;
      r.use_temp = use_temp;
      r.temp = temp;
      r.single = single;
      return r;
   endfunction

   function automatic coil_req_type random_move();
      logic [LEVEL_BITS-1:0] t;
      case ($urandom_range(0, 5))
         0:       t = 8'd0;
         1:       t = 8'd255;
         default: t = LEVEL_BITS'($urandom);
      endcase
      return make_move(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t,
                       $urandom_range(0, 3) == 0);
   endfunction

   // Tick with random content in the fields it ignores
   function automatic coil_req_type random_tick();
      coil_req_type r;
      r = make_move(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    LEVEL_BITS'($urandom), 1'($urandom_range(0, 1)));
      r.op = OP_TICK;
      return r;
   endfunction

   // Offer one request, hold it until taken, then predict its response
   task automatic send_request(input coil_req_type r);
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_direction <= r.dir;
      req_use_temp_speed <= r.use_temp;
      req_temp_speed <= r.temp;
      req_single_cycle <= r.single;
      do @(posedge clock); while (!req_ready);
      coil_expect_q.push_back(step_coils(r));
      n_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Drop the request channel and wait for every response to come back
   task automatic begin_config();
      req_valid <= 1'b0;
      while (coil_expect_q.size() != 0) @(posedge clock);
      n_settings++;
   endtask

   // Write one register; csr_valid stays up for a following write
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, d);
      n_csr++;
   endtask

   task automatic csr_idle();
      csr_valid <= 1'b0;
   endtask

   // Start a move and tick it through to the end, with stray commands on the way
   task automatic run_move();
      int guard;
      guard = 0;
      send_request(random_move());
      while (sq_active && guard < 400) begin
         if ($urandom_range(0, 9) == 0) send_request(random_move());
         else send_request(random_tick());
         guard++;
      end
   endtask

   // Draw a fresh register setting, with junk in the unused upper bits
   task automatic randomise_regs();
      logic [CSR_DATA_BITS-1:0] d;
      d = $urandom;
      case ($urandom_range(0, 7))
         0:       d[LEVEL_BITS-1:0] = 8'd255;
         1:       d[LEVEL_BITS-1:0] = MIN_MAX_LEVEL;
         2:       d[LEVEL_BITS-1:0] = LEVEL_BITS'($urandom_range(0, 1));
         3, 4:    d[LEVEL_BITS-1:0] = LEVEL_BITS'($urandom_range(2, 12));
         default: d[LEVEL_BITS-1:0] = LEVEL_BITS'($urandom_range(2, 255));
      endcase
      csr_write(CSR_MAX_LEVEL, d);
      csr_write(CSR_SPEED_LEVEL, $urandom);
      d = $urandom;
      d[DELAY_FIELD_BITS-1:0] = DELAY_FIELD_BITS'(($urandom_range(0, 3) == 0)
                                                  ? $urandom_range(0, 24)
                                                  : $urandom_range(0, 4));
      csr_write(CSR_DELAY_MIN, d);
      d = $urandom;
      d[DELAY_FIELD_BITS-1:0] = DELAY_FIELD_BITS'(($urandom_range(0, 3) == 0)
                                                  ? $urandom_range(0, 24)
                                                  : $urandom_range(0, 4));
      csr_write(CSR_DELAY_MAX, d);
      d = $urandom;
      d[LENGTH_FIELD_BITS-1:0] = LENGTH_FIELD_BITS'($urandom_range(0, 3));
      csr_write(CSR_FWD_LENGTH, d);
      d = $urandom;
      d[LENGTH_FIELD_BITS-1:0] = LENGTH_FIELD_BITS'($urandom_range(0, 3));
      csr_write(CSR_BWD_LENGTH, d);
   endtask

   // A move, a rejected move and a tick after reset, dropped register writes, then delays for a one-tick hold
   task automatic test_idle_after_reset();
      send_request(make_move(DIR_BWD, 1'b1, 8'hFF, 1'b1));
      send_request(make_move(DIR_FWD, 1'b0, 8'h00, 1'b0));
      send_request(random_tick());
      begin_config();
      csr_write(CSR_MAX_LEVEL, 32'h0000_0000);
      csr_write(CSR_MAX_LEVEL, 32'hFFFF_FF01);
      csr_write(CSR_SPARE, 32'hFFFF_FFFF);
      csr_write(CSR_DELAY_MIN, 32'h0000_0000);
      csr_write(CSR_DELAY_MAX, 32'h0000_0001);
      csr_idle();
   endtask

   // Forward and backward cycles, with a command landing mid-move
   task automatic test_both_directions();
      send_request(make_move(DIR_FWD, 1'b0, 8'd0, 1'b0));
      send_request(random_tick());
      send_request(make_move(DIR_BWD, 1'b1, 8'd5, 1'b0));
      while (sq_active) send_request(random_tick());
      send_request(make_move(DIR_BWD, 1'b1, 8'd0, 1'b0));
      while (sq_active) send_request(random_tick());
   endtask

   // Zero-length move ends at once; single cycle overrides the longest length
   task automatic test_lengths();
      begin_config();
      csr_write(CSR_FWD_LENGTH, 32'hFFFF_FFFF);
      csr_write(CSR_BWD_LENGTH, 32'hFFFF_0000);
      csr_idle();
      send_request(make_move(DIR_BWD, 1'b0, 8'd0, 1'b0));
      send_request(make_move(DIR_FWD, 1'b0, 8'd0, 1'b1));
      while (sq_active) send_request(random_tick());
   endtask

   // Crossed full-scale delays: level one gives the one-tick minimum hold, top level the largest
   task automatic test_clamp_and_delays();
      begin_config();
      csr_write(CSR_MAX_LEVEL, {24'hFFFFFF, MIN_MAX_LEVEL});
      csr_write(CSR_DELAY_MIN, 32'hFFFF_FFFF);
      csr_write(CSR_DELAY_MAX, 32'hFFF0_0000);
      csr_idle();
      send_request(make_move(DIR_FWD, 1'b1, 8'd0, 1'b1));
      while (sq_active) send_request(random_tick());
      send_request(make_move(DIR_BWD, 1'b1, 8'd255, 1'b0));
   endtask

   // Random settings, mostly complete moves with random content
   task automatic test_random_moves(input int count);
      int stop_at, phase_end;
      stop_at = n_sent + count;
      while (n_sent < stop_at) begin
         begin_config();
         randomise_regs();
         csr_idle();
         phase_end = n_sent + $urandom_range(40, 100);
         while (n_sent < phase_end && n_sent < stop_at) begin
            case ($urandom_range(0, 9))
               0:       send_request(random_tick());
               1:       send_request(random_move());
               default: run_move();
            endcase
         end
      end
   endtask

   // Let the last responses out and settle
   task automatic test_drain();
      begin_config();
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (coil_expect_q.size() != 0) begin
         void'(coil_expect_q.pop_front());
         $error("response missing at end of run");
         n_errors++;
      end
   endtask

   task automatic check_field(input string name, input logic [PATTERN_BITS-1:0] want,
                              input logic [PATTERN_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         n_errors++;
      end
   endtask

   // Randomly stall the response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each response with the oldest prediction
   always @(posedge clock) begin : check_rsp
      coil_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (coil_expect_q.size() == 0) begin
            $error("response with nothing expected: pattern %0h", rsp_coil_pattern);
            n_errors++;
         end else begin
            e = coil_expect_q.pop_front();
            check_field("coil_pattern", e.pattern, rsp_coil_pattern);
            check_field("busy_res", PATTERN_BITS'(e.busy), PATTERN_BITS'(rsp_busy_res));
            check_field("done_res", PATTERN_BITS'(e.done), PATTERN_BITS'(rsp_done_res));
            check_field("rejected", PATTERN_BITS'(e.rejected), PATTERN_BITS'(rsp_rejected));
         end
      end
   end

   // Abort when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("stepper_full_step_sequencer_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      cf_max_level = RESET_MAX_LEVEL;
      cf_speed_level = RESET_SPEED_LEVEL;
      cf_delay_min = RESET_DELAY_MIN;
      cf_delay_max = RESET_DELAY_MAX;
      cf_fwd_len = RESET_FWD_LENGTH;
      cf_bwd_len = RESET_BWD_LENGTH;
      sq_active = 1'b0;
      sq_backward = 1'b0;
      sq_phase = 2'd0;
      sq_cycles = '0;
      sq_hold_time = '0;
      sq_hold_left = '0;
      sq_pattern = COILS_OFF;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_both_directions();
      test_lengths();
      test_clamp_and_delays();
      test_random_moves(430);
      // run the tail without any idling
      idle_on = 1'b0;
      test_random_moves(100);
      test_drain();

      $display("Sent %0d requests (%0d moved the coils): %0d moves started, %0d finished,",
               n_sent, n_work, n_moves, n_done);
      $display("%0d refused while busy; checked %0d responses over %0d writes in %0d settings.",
               n_rejected, n_results, n_csr, n_settings);
      if (n_errors == 0) begin
         $display("stepper_full_step_sequencer_unit: match");
      end else begin
         $display("stepper_full_step_sequencer_unit: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ssq_pkg.sv
hw/rtl/ssq_hold_unit.sv
hw/rtl/stepper_full_step_sequencer_unit.sv
tb/testbench.sv
